[rtl/bpld_pkg.sv]
// Shared types and constants for the button press, release and long-press detector.
package bpld_pkg;

  // Fixed widths of the poll, event and configuration words.
  localparam int unsigned IdxWidth    = 3;
  localparam int unsigned EventWidth  = 2;
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgWidth    = 16;

  // Defaults for the module parameters.
  localparam int unsigned NumButtonsDefault = 8;
  localparam int unsigned CountWidthDefault = 16;

  // Configuration reset values.
  localparam logic                   ActiveHighReset    = 1'b1;
  localparam logic                   ShortEnableReset   = 1'b1;
  localparam logic                   ReleaseEnableReset = 1'b1;
  localparam logic                   LongEnableReset    = 1'b1;
  localparam logic [ThreshWidth-1:0] LongThresholdReset = 16'd1000;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ACTIVE_HIGH    = 3'd0,
    REG_SHORT_ENABLE   = 3'd1,
    REG_RELEASE_ENABLE = 3'd2,
    REG_LONG_ENABLE    = 3'd3,
    REG_LONG_THRESHOLD = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                   active_high;
    logic                   short_enable;
    logic                   release_enable;
    logic                   long_enable;
    logic [ThreshWidth-1:0] long_threshold;
  } cfg_t;

endpackage

[rtl/button_press_release_long_detector_top.sv]
// Top level of the button press, release and long-press detector.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   poll     | in        | in_valid_i / in_stall_o | button_index_i, level_i
//   event    | out       | out_valid_o / out_stall_i | event_res_o, event_button_o
//   config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// The edge check and the hold counter update are done in the cycle a poll word
// is accepted, and the event word appears in the output register on the next
// cycle. A new poll is taken every cycle unless the output register is full and
// stalled. Reset clears the stored levels to the inactive level, drops the held
// mark and restores the configuration defaults.
module button_press_release_long_detector_top #(
  parameter int unsigned NUM_BUTTONS = bpld_pkg::NumButtonsDefault,
  parameter int unsigned COUNT_WIDTH = bpld_pkg::CountWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bpld_pkg::IdxWidth-1:0]      button_index_i,
  input  logic                               level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bpld_pkg::EventWidth-1:0]    event_res_o,
  output logic [bpld_pkg::IdxWidth-1:0]      event_button_o,
  input  logic                               cfg_we_i,
  input  logic [bpld_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [bpld_pkg::CfgWidth-1:0]      cfg_data_i
);
  import bpld_pkg::*;

  localparam int unsigned LvlIdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned CmpW    = (COUNT_WIDTH > ThreshWidth) ? COUNT_WIDTH : ThreshWidth;

  cfg_t cfg_q;

  logic [NUM_BUTTONS-1:0]  last_level_q, last_level_d;
  logic                    held_valid_q, held_valid_d;
  logic [IdxWidth-1:0]     held_button_q, held_button_d;
  logic [COUNT_WIDTH-1:0]  hold_count_q, hold_count_d;
  logic                    long_done_q, long_done_d;

  logic                    out_valid_q;
  event_e                  event_q, event_d;
  logic [IdxWidth-1:0]     event_button_q, event_button_d;

  logic                    in_acc;
  logic                    in_range;
  logic [LvlIdxW-1:0]      lvl_idx;
  logic                    prev_level;
  logic                    changed;
  logic                    count_hit;
  logic                    count_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_high    <= ActiveHighReset;
      cfg_q.short_enable   <= ShortEnableReset;
      cfg_q.release_enable <= ReleaseEnableReset;
      cfg_q.long_enable    <= LongEnableReset;
      cfg_q.long_threshold <= LongThresholdReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACTIVE_HIGH:    cfg_q.active_high    <= cfg_data_i[0];
        REG_SHORT_ENABLE:   cfg_q.short_enable   <= cfg_data_i[0];
        REG_RELEASE_ENABLE: cfg_q.release_enable <= cfg_data_i[0];
        REG_LONG_ENABLE:    cfg_q.long_enable    <= cfg_data_i[0];
        REG_LONG_THRESHOLD: cfg_q.long_threshold <= cfg_data_i[ThreshWidth-1:0];
        default: ;
      endcase
    end
  end

  // The output register frees up when its word is taken in the same cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_range   = 32'(button_index_i) < 32'(NUM_BUTTONS);

  if (IdxWidth >= LvlIdxW) begin : g_idx_trunc
    assign lvl_idx = button_index_i[LvlIdxW-1:0];
  end else begin : g_idx_ext
    assign lvl_idx = LvlIdxW'(button_index_i);
  end

  assign prev_level = last_level_q[lvl_idx];
  assign changed    = level_i != prev_level;
  assign count_hit  = CmpW'(hold_count_q) >= CmpW'(cfg_q.long_threshold);
  assign count_full = &hold_count_q;

  always_comb begin
    last_level_d   = last_level_q;
    held_valid_d   = held_valid_q;
    held_button_d  = held_button_q;
    hold_count_d   = hold_count_q;
    long_done_d    = long_done_q;
    event_d        = EV_NONE;

    if (in_range) begin
      if (changed && (level_i == cfg_q.active_high)) begin
        held_valid_d  = 1'b1;
        held_button_d = button_index_i;
        hold_count_d  = '0;
        long_done_d   = 1'b0;
        if (cfg_q.short_enable) begin
          event_d = EV_SHORT;
        end
      end else if (changed) begin
        if (cfg_q.release_enable && held_valid_q && !long_done_q) begin
          event_d = EV_RELEASE;
        end
        held_valid_d = 1'b0;
        long_done_d  = 1'b0;
        hold_count_d = '0;
      end else if (cfg_q.long_enable && held_valid_q &&
                   (held_button_q == button_index_i) && !long_done_q) begin
        if (count_hit) begin
          event_d      = EV_LONG;
          hold_count_d = '0;
          long_done_d  = 1'b1;
        end else if (!count_full) begin
          hold_count_d = hold_count_q + COUNT_WIDTH'(1);
        end
      end
      last_level_d[lvl_idx] = level_i;
    end

    event_button_d = (event_d == EV_NONE) ? '0 : button_index_i;
  end

  // Detector state moves only on an accepted poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q  <= '0;
      held_valid_q  <= 1'b0;
      held_button_q <= '0;
      hold_count_q  <= '0;
      long_done_q   <= 1'b0;
    end else if (in_acc) begin
      last_level_q  <= last_level_d;
      held_valid_q  <= held_valid_d;
      held_button_q <= held_button_d;
      hold_count_q  <= hold_count_d;
      long_done_q   <= long_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      event_q        <= event_d;
      event_button_q <= event_button_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign event_button_o = event_button_q;

  // A long press can only be marked while a button is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_done_q |-> held_valid_q)
    else $error("long press mark set without a held button");

  // The hold counter restarts when the long press fires.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_done_q |-> (hold_count_q == '0))
    else $error("hold counter not cleared after long press");

  // An accepted poll always leaves a word in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted poll produced no event word");

  // An empty event word names no button.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q == EV_NONE)) |-> (event_button_q == '0))
    else $error("empty event carries a button index");

  // The stored counter never runs past the threshold while still armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_range && !changed && cfg_q.long_enable && held_valid_q &&
     (held_button_q == button_index_i) && !long_done_q && count_hit)
    |=> long_done_q)
    else $error("threshold reached without long press");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the button press, release and long-press detector.
module tb_top;
  import bpld_pkg::*;

  typedef struct packed {
    event_e                ev;
    logic [IdxWidth-1:0]   btn;
  } event_word_t;

  logic                   clk_i;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid       = 1'b0;
  logic [IdxWidth-1:0]    button_index   = '0;
  logic                   level          = 1'b0;
  logic                   out_stall      = 1'b0;
  logic                   cfg_we         = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index      = REG_ACTIVE_HIGH;
  logic [CfgWidth-1:0]    cfg_data       = '0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [EventWidth-1:0]  event_res_o;
  logic [IdxWidth-1:0]    event_button_o;

  // Our own copy of the settings and of the detector state.
  cfg_t settings = '{ActiveHighReset, ShortEnableReset, ReleaseEnableReset,
                     LongEnableReset, LongThresholdReset};
  logic [NumButtonsDefault-1:0]  pin_seen    = {NumButtonsDefault{~ActiveHighReset}};
  logic                          held        = 1'b0;
  logic [IdxWidth-1:0]           held_btn    = '0;
  logic [CountWidthDefault-1:0]  hold_cnt    = '0;
  logic                          long_fired  = 1'b0;

  event_word_t pending_events[$];

  int gap_max       = 0;
  int burst_left    = 0;
  int stall_run_max = 0;
  int hold_req      = 0;
  int items_sent    = 0;
  int err_count     = 0;

  button_press_release_long_detector_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .button_index_i (button_index),
    .level_i        (level),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .event_res_o    (event_res_o),
    .event_button_o (event_button_o),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Updates the detector state for one poll word and returns the event it gives.
  function automatic event_word_t poll_outcome(logic [IdxWidth-1:0] idx, logic lvl);
    event_word_t w;
    logic        prev;
    w.ev  = EV_NONE;
    w.btn = '0;
    prev  = pin_seen[idx];
    if (lvl != prev && lvl == settings.active_high) begin
      held       = 1'b1;
      held_btn   = idx;
      hold_cnt   = '0;
      long_fired = 1'b0;
      if (settings.short_enable) w.ev = EV_SHORT;
    end else if (lvl != prev) begin
      // Any release frees the held mark, even for a button that was not held.
      if (settings.release_enable && held && !long_fired) w.ev = EV_RELEASE;
      held       = 1'b0;
      long_fired = 1'b0;
      hold_cnt   = '0;
    end else if (settings.long_enable && held && held_btn == idx && !long_fired) begin
      if (hold_cnt >= settings.long_threshold) begin
        w.ev       = EV_LONG;
        hold_cnt   = '0;
        long_fired = 1'b1;
      end else if (hold_cnt != '1) begin
        hold_cnt = hold_cnt + 1'b1;
      end
    end
    pin_seen[idx] = lvl;
    if (w.ev != EV_NONE) w.btn = idx;
    return w;
  endfunction

  // Event receiver: bursty stall pattern, plus a long hold-off on request.
  initial begin
    int  run_left;
    int  hold_left;
    bit  stalling;
    run_left  = 0;
    hold_left = 0;
    stalling  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (run_left == 0) begin
        stalling = 1'($urandom_range(0, 1));
        run_left = stalling ? $urandom_range(1, (stall_run_max > 0) ? stall_run_max : 1)
                            : $urandom_range(1, 10);
      end
      run_left--;
      out_stall <= (hold_left != 0) || (stall_run_max != 0 && stalling);
      if (hold_left != 0) hold_left--;
    end
  end

  // Event checker: an event word is taken at the edge after a negedge that sees
  // valid high and stall low, so it is compared here.
  initial begin
    event_word_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event word: event_res %0d event_button %0d",
                 event_res_o, event_button_o);
          err_count++;
        end else begin
          want = pending_events.pop_front();
          if (event_res_o !== want.ev) begin
            $error("event_res mismatch: expected %0d actual %0d", want.ev, event_res_o);
            err_count++;
          end
          if (event_button_o !== want.btn) begin
            $error("event_button mismatch: expected %0d actual %0d",
                   want.btn, event_button_o);
            err_count++;
          end
        end
      end
    end
  end

  // Offers one poll word and returns at the edge where it is taken.
  task automatic send_poll(logic [IdxWidth-1:0] idx, logic lvl);
    bit ready;
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    in_valid     <= 1'b1;
    button_index <= idx;
    level        <= lvl;
    do begin
      @(negedge clk_i);
      ready = !in_stall_o;
      @(posedge clk_i);
    end while (!ready);
    pending_events.push_back(poll_outcome(idx, lvl));
    items_sent++;
  endtask

  // Stops sending until every expected event word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_reg_e r, logic [CfgWidth-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk_i);
    case (r)
      REG_ACTIVE_HIGH:    settings.active_high    = d[0];
      REG_SHORT_ENABLE:   settings.short_enable   = d[0];
      REG_RELEASE_ENABLE: settings.release_enable = d[0];
      REG_LONG_ENABLE:    settings.long_enable    = d[0];
      REG_LONG_THRESHOLD: settings.long_threshold = d;
      default: ;
    endcase
  endtask

  // Writes all registers; the unused upper bits of the flag writes are random.
  task automatic apply_config(cfg_t c);
    logic [CfgWidth-2:0] pad;
    pad = (CfgWidth-1)'($urandom);
    put_reg(REG_ACTIVE_HIGH, {pad, c.active_high});
    pad = (CfgWidth-1)'($urandom);
    put_reg(REG_SHORT_ENABLE, {pad, c.short_enable});
    pad = (CfgWidth-1)'($urandom);
    put_reg(REG_RELEASE_ENABLE, {pad, c.release_enable});
    pad = (CfgWidth-1)'($urandom);
    put_reg(REG_LONG_ENABLE, {pad, c.long_enable});
    put_reg(REG_LONG_THRESHOLD, c.long_threshold);
    cfg_we <= 1'b0;
  endtask

  // Press, hold and release sequences with some noise mixed in.
  task automatic run_sequences(int n, int thr);
    int                  target;
    int                  cap;
    int                  hold_len;
    logic [IdxWidth-1:0] b;
    logic [IdxWidth-1:0] c;
    logic                act;
    target = items_sent + n;
    while (items_sent < target) begin
      act = settings.active_high;
      if ($urandom_range(0, 9) < 7) begin
        b = IdxWidth'($urandom);
        // A button that already reads active must be released before a press.
        if (pin_seen[b] == act) send_poll(b, !act);
        send_poll(b, act);
        cap      = (thr > 30) ? 30 : thr + 2;
        hold_len = $urandom_range(0, cap);
        repeat (hold_len) begin
          case ($urandom_range(0, 11))
            0, 1: begin
              c = IdxWidth'($urandom);
              send_poll(c, pin_seen[c]);
            end
            2: begin
              c = IdxWidth'($urandom);
              send_poll(c, 1'($urandom));
            end
            default: send_poll(b, act);
          endcase
        end
        send_poll(b, !act);
      end else begin
        repeat ($urandom_range(1, 6)) send_poll(IdxWidth'($urandom), 1'($urandom));
      end
    end
  endtask

  // Reset settings: press, hold poll, release, and a release of a button that
  // is not the held one.
  task automatic test_reset_defaults();
    gap_max       = 3;
    stall_run_max = 4;
    send_poll(3'd0, 1'b1);
    send_poll(3'd0, 1'b1);
    send_poll(3'd0, 1'b0);
    send_poll(3'd7, 1'b0);
    send_poll(3'd7, 1'b1);
    send_poll(3'd3, 1'b1);
    send_poll(3'd7, 1'b0);
    send_poll(3'd3, 1'b0);
  endtask

  // With a zero threshold the first hold poll gives the long press, and the
  // release after it gives no event.
  task automatic test_zero_threshold();
    drain();
    apply_config('{1'b1, 1'b1, 1'b1, 1'b1, 16'd0});
    send_poll(3'd2, 1'b1);
    send_poll(3'd2, 1'b1);
    send_poll(3'd2, 1'b1);
    send_poll(3'd2, 1'b0);
    send_poll(3'd2, 1'b1);
    send_poll(3'd2, 1'b0);
  endtask

  // Active-low polarity with every event disabled and the largest threshold.
  task automatic test_all_disabled();
    drain();
    apply_config('{1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF});
    for (int b = 0; b < 4; b++) begin
      send_poll(b[IdxWidth-1:0], 1'b1);
      send_poll(b[IdxWidth-1:0], 1'b0);
    end
  endtask

  // The receiver holds off while polls keep coming, so the input stalls.
  task automatic test_output_backpressure();
    drain();
    apply_config('{1'b1, 1'b1, 1'b1, 1'b1, 16'd3});
    gap_max       = 0;
    stall_run_max = 0;
    hold_req      = 300;
    run_sequences(40, 3);
  endtask

  task automatic test_random_phases();
    cfg_t c;
    int   thr;
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      c.active_high    = 1'($urandom_range(0, 1));
      c.short_enable   = (ph < 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      c.release_enable = (ph < 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      c.long_enable    = (ph < 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      case (ph % 6)
        0:       thr = 1;
        1:       thr = 0;
        2:       thr = 65535;
        3:       thr = 1000;
        default: thr = $urandom_range(2, 12);
      endcase
      c.long_threshold = ThreshWidth'(thr);
      if (ph % 4 == 0) begin
        gap_max       = 0;
        stall_run_max = 0;
      end else begin
        gap_max       = $urandom_range(1, 8);
        stall_run_max = $urandom_range(1, 12);
      end
      apply_config(c);
      run_sequences(125, thr);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_threshold();
    test_all_disabled();
    test_output_backpressure();
    test_random_phases();
    drain();
    repeat (5) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $error("%0d expected event words never arrived", pending_events.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[button_press_release_long_detector_top.f]
rtl/bpld_pkg.sv
rtl/button_press_release_long_detector_top.sv
bench/tb_top.sv
